FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cdg_pkg.sv
// Types, constants and register map of the greedy change dispenser.
package cdg_pkg;

	// Sizes of the datapath.
	localparam int SLOTS       = 7;
	localparam int COUNT_BITS  = 8;
	localparam int AMOUNT_BITS = 16;
	localparam int DENOM_BITS  = 16;
	localparam int NUM_DENOM   = 7;
	localparam int CMP_BITS    = (AMOUNT_BITS > DENOM_BITS) ? AMOUNT_BITS : DENOM_BITS;
	localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Configuration port.
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;
	localparam int REG_BITS  = ADDR_BITS - 2;

	typedef logic [REG_BITS-1:0]    reg_idx_t;
	typedef logic [SLOT_BITS-1:0]   slot_t;
	typedef logic [DENOM_BITS-1:0]  denom_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [AMOUNT_BITS-1:0] amount_t;

	// Register indexes.
	localparam reg_idx_t REG_DENOM_LAST = reg_idx_t'(NUM_DENOM - 1);
	localparam reg_idx_t REG_RESTOCK    = reg_idx_t'(NUM_DENOM);

	// Reset values of the registers.
	localparam denom_t DENOM_RESET [NUM_DENOM] = '{
		denom_t'(17), denom_t'(11), denom_t'(7), denom_t'(5),
		denom_t'(3), denom_t'(2), denom_t'(1)
	};
	localparam count_t RESTOCK_RESET = count_t'(2);

	// Input commands.
	localparam logic CMD_PAYOUT  = 1'b0;
	localparam logic CMD_RESTOCK = 1'b1;

	// Beat payloads.
	typedef struct packed {
		logic    command;
		amount_t amount;
	} cdg_in_t;

	typedef struct packed {
		logic   ok;
		count_t count_0;
		count_t count_1;
		count_t count_2;
		count_t count_3;
		count_t count_4;
		count_t count_5;
		count_t count_6;
	} cdg_out_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} cdg_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic take_coin;
		logic next_slot;
		logic commit;
	} cdg_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic coin_ok;
		logic last_slot;
		logic out_free;
	} cdg_status_t;

endpackage

FILE: hw/rtl/change_dispenser_greedy.sv
// Top level of the greedy change dispenser.
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one beat per item: command
// selects pay out or restock, amount is the change to give. The output channel
// (out_valid, out_ready, out_data) returns one beat per item: ok and the coins taken
// from each of the seven slots, zero counts on failure or restock.
// The APB port holds the seven denominations (addresses 0x00 to 0x18, slot 0 tried
// first, program them descending) and the restock count (address 0x1C).
// Timing: a restock goes from acceptance straight to the done state, and a pay out
// first walks the slots; the slot walk subtracts one coin per cycle and moves on to
// the next slot when no coin fits. The result beat is registered once the output
// register is free. One item is worked on at a time; in_ready is high only while
// the walker is idle, so it returns with the result beat.
// A finished result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the following result in the walker until
// the register frees up.
// Reset clears both channels, loads the reset denominations 17, 11, 7, 5, 3, 2, 1,
// sets the restock count to 2 and fills every slot with 2 coins.
module change_dispenser_greedy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cdg_pkg::cdg_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cdg_pkg::cdg_out_t             out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdg_pkg::ADDR_BITS-1:0] paddr,
	input  logic [cdg_pkg::DATA_BITS-1:0] pwdata,
	output logic [cdg_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import cdg_pkg::*;

	cdg_cmd_t    cmd;
	cdg_status_t status;

	assign pready = 1'b1;

	// Sequencer of the slot walk.
	cdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Registers, stock and result.
	cdg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);

endmodule

FILE: hw/rtl/cdg_ctrl.sv
// Controller state machine of the change dispenser.
module cdg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cdg_pkg::cdg_in_t    in_data,
	output logic                in_ready,
	input  cdg_pkg::cdg_status_t status,
	output cdg_pkg::cdg_cmd_t   cmd
);
	import cdg_pkg::*;

	cdg_state_t state_q;
	cdg_state_t state_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a restock goes straight to the result, a pay out walks the slots.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_data.command == CMD_RESTOCK) ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (!status.coin_ok && status.last_slot) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: one coin per cycle while the slot allows it, else move on.
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept;
			end
			ST_WALK: begin
				cmd.take_coin = status.coin_ok;
				cmd.next_slot = !status.coin_ok && !status.last_slot;
			end
			ST_DONE: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/cdg_dp.sv
// Datapath of the change dispenser: registers, stock, walk counters and result.
module cdg_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdg_pkg::cdg_in_t                  in_data,
	input  cdg_pkg::cdg_cmd_t                 cmd,
	output cdg_pkg::cdg_status_t              status,
	output cdg_pkg::cdg_out_t                 out_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cdg_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [cdg_pkg::DATA_BITS-1:0]     pwdata,
	output logic [cdg_pkg::DATA_BITS-1:0]     prdata
);
	import cdg_pkg::*;

	denom_t   denom_q [NUM_DENOM];
	count_t   restock_q;
	count_t   stock_q [SLOTS];
	count_t   taken_q [SLOTS];
	slot_t    slot_q;
	amount_t  rem_q;
	logic     restock_item_q;
	logic     out_valid_q;
	cdg_out_t out_q;

	reg_idx_t              reg_idx;
	logic                  cfg_wr;
	denom_t                cur_denom;
	logic [CMP_BITS-1:0]   rem_ext;
	logic [CMP_BITS-1:0]   den_ext;
	logic                  pay_ok;
	count_t                cnt [7];

	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOM; i++) begin
				denom_q[i] <= DENOM_RESET[i];
			end
			restock_q <= RESTOCK_RESET;
		end else if (cfg_wr) begin
			if (reg_idx <= REG_DENOM_LAST) begin
				denom_q[reg_idx] <= pwdata[DENOM_BITS-1:0];
			end else if (reg_idx == REG_RESTOCK) begin
				restock_q <= pwdata[COUNT_BITS-1:0];
			end
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		if (reg_idx <= REG_DENOM_LAST) begin
			prdata = DATA_BITS'(denom_q[reg_idx]);
		end else if (reg_idx == REG_RESTOCK) begin
			prdata = DATA_BITS'(restock_q);
		end
	end

	// A coin fits when the slot has a value, the remainder covers it and stock is left.
	always_comb begin
		cur_denom      = denom_q[slot_q];
		rem_ext        = CMP_BITS'(rem_q);
		den_ext        = CMP_BITS'(cur_denom);
		status.coin_ok = (cur_denom != '0) && (rem_ext >= den_ext)
			&& (taken_q[slot_q] != stock_q[slot_q]);
		status.last_slot = (slot_q == slot_t'(SLOTS - 1));
		status.out_free  = !out_valid_q || out_ready;
	end

	// Walk state: slot pointer, remainder and coins taken so far.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q         <= '0;
			rem_q          <= in_data.amount;
			restock_item_q <= in_data.command;
			for (int i = 0; i < SLOTS; i++) begin
				taken_q[i] <= '0;
			end
		end else if (cmd.take_coin) begin
			rem_q           <= AMOUNT_BITS'(rem_ext - den_ext);
			taken_q[slot_q] <= taken_q[slot_q] + count_t'(1);
		end else if (cmd.next_slot) begin
			slot_q <= slot_q + slot_t'(1);
		end
	end

	assign pay_ok = restock_item_q || (rem_q == '0);

	// Stock: reload on restock, lowered only by a pay out that covers the amount.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				stock_q[i] <= RESTOCK_RESET;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (restock_item_q) begin
					stock_q[i] <= restock_q;
				end else if (pay_ok) begin
					stock_q[i] <= stock_q[i] - taken_q[i];
				end
			end
		end
	end

	// Per-slot counts of the result; unused slots, restocks and failures report zero.
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			cnt[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (pay_ok && !restock_item_q) begin
				cnt[i] = taken_q[i];
			end
		end
	end

	// Output register; it holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.ok      <= pay_ok;
			out_q.count_0 <= cnt[0];
			out_q.count_1 <= cnt[1];
			out_q.count_2 <= cnt[2];
			out_q.count_3 <= cnt[3];
			out_q.count_4 <= cnt[4];
			out_q.count_5 <= cnt[5];
			out_q.count_6 <= cnt[6];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/cdg_chk.sv
// Port-level checker of the change dispenser and its bind to the top level.
`include "assert_macros.svh"

module cdg_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input cdg_pkg::cdg_in_t              in_data,
	input logic                          out_valid,
	input logic                          out_ready,
	input cdg_pkg::cdg_out_t             out_data,
	input logic                          pready
);
	import cdg_pkg::*;

	logic counts_zero;

	assign counts_zero = (out_data.count_0 == '0) && (out_data.count_1 == '0)
		&& (out_data.count_2 == '0) && (out_data.count_3 == '0)
		&& (out_data.count_4 == '0) && (out_data.count_5 == '0)
		&& (out_data.count_6 == '0);

	// A failed pay out gives no coins.
	`ASSERT_IMPL(a_fail_no_coins, out_valid && !out_data.ok, counts_zero, "failure beat with coins")

	// Every accepted item keeps the input closed for at least the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

	// A stalled result beat holds.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
		"stalled result beat changed")

	// The register port never inserts wait states.
	`ASSERT_IMPL(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind change_dispenser_greedy cdg_chk u_cdg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);

FILE: bench/change_dispenser_greedy_tb.sv
// Self-checking testbench for the greedy change dispenser: random traffic against a coin ledger.
module change_dispenser_greedy_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdg_pkg::*;

	localparam int          HALF_PERIOD  = 5;
	localparam int          RESET_CYCLES = 12;
	localparam int          SETTLE       = 4;
	localparam int          TAIL_CYCLES  = 64;
	localparam int          LONG_HOLD    = 400;
	localparam int          TIMEOUT_NS   = 100_000_000;
	localparam int          OUT_BITS     = $bits(cdg_out_t);
	localparam int unsigned AMOUNT_MAX   = (1 << AMOUNT_BITS) - 1;

	// Denomination and restock settings that a phase can run under.
	typedef enum {
		CFG_SORTED_SMALL,
		CFG_SORTED_WIDE,
		CFG_ALL_MAX,
		CFG_ALL_ONES,
		CFG_EMPTY_STOCK,
		CFG_SCRAMBLED
	} cfg_profile_t;

	// Ways in which the receiver paces out_ready.
	typedef enum {
		RX_FREE,
		RX_COIN_FLIP,
		RX_ONE_IN_FOUR,
		RX_RARE_STALL
	} rx_mode_t;

	// Mirror of the dispenser: denominations, coin stock and the payouts still owed.
	class coin_ledger;
		int unsigned slot_value [SLOTS];
		int unsigned refill;
		int unsigned coins [SLOTS];
		cdg_out_t    due_payouts [$];
		int          errors;

		function new();
			int s;
			for (s = 0; s < SLOTS; s++) begin
				slot_value[s] = DENOM_RESET[s];
				coins[s] = RESTOCK_RESET;
			end
			refill = RESTOCK_RESET;
			errors = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [DATA_BITS-1:0] value);
			if (idx <= REG_DENOM_LAST) begin
				slot_value[idx] = value[DENOM_BITS-1:0];
			end else if (idx == REG_RESTOCK) begin
				refill = value[COUNT_BITS-1:0];
			end
		endfunction

		function int unsigned coins_left();
			int unsigned total;
			int s;
			total = 0;
			for (s = 0; s < SLOTS; s++) total += coins[s];
			return total;
		endfunction

		// Work out the payout for an accepted request and update the stock.
		function void post_request(cdg_in_t req);
			logic [OUT_BITS-1:0] flat;
			int unsigned         taken [SLOTS];
			longint unsigned     owed;
			longint unsigned     fit;
			int                  s;
			flat = '0;
			if (req.command == CMD_RESTOCK) begin
				for (s = 0; s < SLOTS; s++) coins[s] = refill;
				flat[OUT_BITS-1] = 1'b1;
				due_payouts.push_back(cdg_out_t'(flat));
				return;
			end
			// Greedy walk from slot 0, limited by what each slot still holds.
			owed = req.amount;
			for (s = 0; s < SLOTS; s++) begin
				taken[s] = 0;
				if (slot_value[s] == 0 || owed == 0) continue;
				fit = owed / slot_value[s];
				if (fit > coins[s]) fit = coins[s];
				taken[s] = fit;
				owed -= fit * slot_value[s];
			end
			// Only a complete payout touches the stock; a short one reports zeros.
			if (owed == 0) begin
				flat[OUT_BITS-1] = 1'b1;
				for (s = 0; s < SLOTS; s++) begin
					coins[s] -= taken[s];
					flat[(SLOTS-1-s)*COUNT_BITS +: COUNT_BITS] = count_t'(taken[s]);
				end
			end
			due_payouts.push_back(cdg_out_t'(flat));
		endfunction

		// Compare a result beat with the oldest payout owed.
		function void match_payout(cdg_out_t got);
			cdg_out_t            want;
			logic [OUT_BITS-1:0] w;
			logic [OUT_BITS-1:0] g;
			int                  s;
			if (due_payouts.size() == 0) begin
				$error("result beat with no request pending: %h", got);
				errors++;
				return;
			end
			want = due_payouts.pop_front();
			w = want;
			g = got;
			if (got.ok !== want.ok) begin
				$error("ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
				errors++;
			end
			for (s = 0; s < SLOTS; s++) begin
				if (g[(SLOTS-1-s)*COUNT_BITS +: COUNT_BITS]
						!== w[(SLOTS-1-s)*COUNT_BITS +: COUNT_BITS]) begin
					$error("count_%0d mismatch: expected %0d, actual %0d", s,
						w[(SLOTS-1-s)*COUNT_BITS +: COUNT_BITS],
						g[(SLOTS-1-s)*COUNT_BITS +: COUNT_BITS]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	cdg_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cdg_out_t             out_data;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_BITS-1:0] paddr     = '0;
	logic [DATA_BITS-1:0] pwdata    = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	coin_ledger ledger = new();
	int         burst_left = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	rx_mode_t   rx_mode = RX_FREE;
	int         rx_left = 0;
	int         rx_tick = 0;

	change_dispenser_greedy u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Watch both channels at the rising edge; results are checked before requests are noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) ledger.match_payout(out_data);
			if (in_valid && in_ready) ledger.post_request(in_data);
		end
	end

	// Receiver pacing: stretches of different stall patterns, plus a long hold on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE: begin
					out_ready <= 1'b1;
				end
				RX_COIN_FLIP: begin
					out_ready <= $urandom_range(0, 1);
				end
				RX_ONE_IN_FOUR: begin
					out_ready <= (rx_tick % 4 == 0);
				end
				default: begin
					out_ready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	function automatic cdg_in_t make_request(logic cmd, amount_t amt);
		cdg_in_t req;
		req.command = cmd;
		req.amount = amt;
		return req;
	endfunction

	// Mostly amounts that the current stock could cover, the rest noise and restocks.
	function automatic cdg_in_t pick_request();
		cdg_in_t     req;
		int unsigned roll;
		int unsigned sum;
		int unsigned part;
		int          s;
		req = make_request(CMD_PAYOUT, '0);
		roll = $urandom_range(0, 99);
		if (roll < 8 || (ledger.coins_left() < 3 && roll < 50)) begin
			req = make_request(CMD_RESTOCK, amount_t'($urandom));
		end else if (roll < 60) begin
			sum = 0;
			for (s = 0; s < SLOTS; s++) begin
				part = $urandom_range(0, ledger.coins[s]) * ledger.slot_value[s];
				if (sum + part <= AMOUNT_MAX) sum += part;
			end
			req.amount = amount_t'(sum);
		end else if (roll < 75) begin
			req.amount = amount_t'($urandom_range(0, 200));
		end else if (roll < 82) begin
			case ($urandom_range(0, 2))
				0: req.amount = '0;
				1: req.amount = '1;
				default: req.amount = amount_t'(1);
			endcase
		end else begin
			req.amount = amount_t'($urandom);
		end
		return req;
	endfunction

	// Offer one request; a new burst starts after a random gap, which may be zero.
	task automatic send_request(input cdg_in_t req);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// Stop offering and wait for every owed payout to come back.
	task automatic pause_sender();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.due_payouts.size() != 0) @(negedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write all denominations and the restock count for a profile; upper bits carry junk.
	task automatic program_profile(input cfg_profile_t profile);
		int unsigned vals [$];
		int unsigned refill;
		int          s;
		for (s = 0; s < SLOTS; s++) begin
			case (profile)
				CFG_ALL_MAX:     vals.push_back(AMOUNT_MAX);
				CFG_ALL_ONES:    vals.push_back(1);
				CFG_SORTED_WIDE: vals.push_back($urandom_range(1, AMOUNT_MAX));
				CFG_SCRAMBLED: begin
					vals.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
				end
				default:         vals.push_back($urandom_range(1, 40));
			endcase
		end
		case (profile)
			CFG_ALL_MAX, CFG_ALL_ONES: begin
				refill = 255;
			end
			CFG_EMPTY_STOCK: begin
				refill = 0;
			end
			CFG_SCRAMBLED: begin
				// Left unsorted, and at least one slot worth nothing.
				vals[$urandom_range(0, SLOTS - 1)] = 0;
				refill = $urandom_range(1, 10);
			end
			CFG_SORTED_WIDE: begin
				vals.rsort();
				refill = $urandom_range(1, 20);
			end
			default: begin
				vals.rsort();
				if ($urandom_range(0, 1)) vals[SLOTS - 1] = 1;
				refill = $urandom_range(1, 12);
			end
		endcase
		for (s = 0; s < NUM_DENOM; s++) begin
			write_register(reg_idx_t'(s), {16'($urandom), 16'(vals[s])});
		end
		write_register(REG_RESTOCK, {24'($urandom), 8'(refill)});
	endtask

	// Short hand-picked sequence on the reset settings (17, 11, 7, 5, 3, 2, 1; two coins each).
	task automatic run_directed();
		cdg_in_t script [$];
		script.push_back(make_request(CMD_PAYOUT, amount_t'(0)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(92)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(1)));
		script.push_back(make_request(CMD_RESTOCK, '1));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(93)));
		script.push_back(make_request(CMD_PAYOUT, '1));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(17)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(34)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(16'h8000)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(1)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(2)));
		script.push_back(make_request(CMD_RESTOCK, '0));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(6)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(46)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(16'h5555)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(16'hAAAA)));
		script.push_back(make_request(CMD_PAYOUT, amount_t'(0)));
		foreach (script[i]) send_request(script[i]);
	endtask

	// One phase: drain, reprogram while idle, then random traffic.
	task automatic run_phase(input cfg_profile_t profile, input int count,
			input bit long_hold, input bit mid_pause);
		int n;
		pause_sender();
		repeat (SETTLE) @(negedge clk);
		program_profile(profile);
		if (long_hold) hold_req = 1'b1;
		if (profile == CFG_ALL_MAX || profile == CFG_ALL_ONES || $urandom_range(0, 1)) begin
			send_request(make_request(CMD_RESTOCK, amount_t'($urandom)));
		end
		for (n = 0; n < count; n++) begin
			if (mid_pause && n == count / 2) pause_sender();
			send_request(pick_request());
		end
	endtask

	initial begin
		int k;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_phase(CFG_ALL_MAX, 12, 1'b0, 1'b0);
		run_phase(CFG_ALL_ONES, 8, 1'b0, 1'b0);
		run_phase(CFG_EMPTY_STOCK, 15, 1'b0, 1'b0);
		run_phase(CFG_SCRAMBLED, 100, 1'b0, 1'b1);
		for (k = 0; k < 5; k++) begin
			run_phase(CFG_SORTED_SMALL, 120, k == 0, k == 2);
		end
		run_phase(CFG_SORTED_WIDE, 100, 1'b0, 1'b0);
		pause_sender();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (ledger.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
